[rtl/acf_pkg.sv]
// ============================================================================
// acf_pkg
// Shared constants, state encoding and divider result type for the sample
// autocorrelation core.
// ============================================================================
package acf_pkg;

    // Default store depth, the longest series that one run covers.
    localparam int MAX_LEN_DEF = 64;

    // Fixed field widths of the channels.
    localparam int SAMPLE_W = 16;
    localparam int LAG_W    = 6;
    localparam int VALUE_W  = 16;

    // Result format is Q2.14; the quotient has one integer bit and 14 fraction bits.
    localparam int FRAC_W   = 14;
    localparam int QUOT_W   = FRAC_W + 1;
    localparam int STEP_W   = $clog2(QUOT_W);

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEV,
        ST_MAC,
        ST_DIV,
        ST_EMIT
    } t_state;

    // Status that the divider hands back to the sequencer.
    typedef struct packed {
        logic                       done;
        logic                       undef;
        logic signed [VALUE_W-1:0]  value;
    } t_div_res;

endpackage

[rtl/acf_if.sv]
// ============================================================================
// acf_if
// Valid/ready channel interfaces: sample input and per-lag result output.
// ============================================================================
interface acf_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [acf_pkg::SAMPLE_W-1:0]  sample;
    logic                                 last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface acf_out_if;
    logic                                 valid;
    logic                                 ready;
    logic        [acf_pkg::LAG_W-1:0]     lag;
    logic signed [acf_pkg::VALUE_W-1:0]   acf_value;
    logic                                 undefined;
    logic                                 last_lag;

    modport source (output valid, output lag, output acf_value, output undefined,
                    output last_lag, input ready);
    modport sink   (input valid, input lag, input acf_value, input undefined,
                    input last_lag, output ready);
endinterface

[rtl/acf_ram.sv]
// ============================================================================
// acf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module acf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/acf_div.sv]
// ============================================================================
// acf_div
// Restoring long divider: |num| * 2^14 / den, one quotient bit per cycle,
// sign applied at the end so the result truncates toward zero.
// ============================================================================
module acf_div #(
    parameter int ACC_W = 55
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [ACC_W-1:0] i_num,
    input  logic signed [ACC_W-1:0] i_den,
    output acf_pkg::t_div_res       o_res
);

    logic                           r_busy;
    logic                           r_done;
    logic                           r_undef;
    logic                           r_neg;
    logic [acf_pkg::STEP_W-1:0]     r_step;
    logic [ACC_W-1:0]               r_rem;
    logic [ACC_W-1:0]               r_dvs;
    logic [acf_pkg::QUOT_W-1:0]     r_q;

    logic [ACC_W-1:0]               w_rr;
    logic                           w_ge;
    logic [ACC_W-1:0]               w_abs;
    logic signed [acf_pkg::VALUE_W-1:0] w_qs;

    // The first step compares the unshifted remainder; later steps shift first.
    assign w_rr  = (r_step == '0) ? r_rem : {r_rem[ACC_W-2:0], 1'b0};
    assign w_ge  = (w_rr >= r_dvs);
    assign w_abs = i_num[ACC_W-1] ? ACC_W'(-i_num) : ACC_W'(i_num);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= (i_den != '0);
                r_done <= (i_den == '0);
            end else if (r_busy && (r_step == acf_pkg::STEP_W'(acf_pkg::FRAC_W))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: one compare-subtract per cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_undef <= (i_den == '0);
            r_neg   <= i_num[ACC_W-1];
            r_rem   <= w_abs;
            r_dvs   <= ACC_W'(i_den);
            r_q     <= '0;
            r_step  <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? (w_rr - r_dvs) : w_rr;
            r_q    <= {r_q[acf_pkg::QUOT_W-2:0], w_ge};
            r_step <= r_step + acf_pkg::STEP_W'(1);
        end
    end

    // Signed result; a zero denominator forces zero.
    always_comb begin
        w_qs = acf_pkg::VALUE_W'(r_q);
        if (r_undef) begin
            o_res.value = '0;
        end else if (r_neg) begin
            o_res.value = -w_qs;
        end else begin
            o_res.value = w_qs;
        end
        o_res.done  = r_done;
        o_res.undef = r_undef;
    end

    ap_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && (r_step == acf_pkg::STEP_W'(acf_pkg::FRAC_W)))
            |=> (r_done && !r_busy))
        else $error("divider did not finish after the last quotient bit");

    ap_rem_below_dvs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_step != '0)) |-> (r_rem < r_dvs))
        else $error("divider remainder not below divisor");

    ap_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_q <= acf_pkg::QUOT_W'(1 << acf_pkg::FRAC_W)))
        else $error("quotient exceeds one");

endmodule

[rtl/sample_autocorrelation_core.sv]
// ============================================================================
// sample_autocorrelation_core
// Collects a signed series, then emits the biased sample autocorrelation of
// every lag in Q2.14 using one shared multiplier and one shared divider.
// ============================================================================
//
//  channel   dir  handshake           payload
//  i_in      in   valid/ready         sample[15:0] signed, last_sample
//  o_res     out  valid/ready         lag[5:0], acf_value[15:0] signed,
//                                     undefined, last_lag
//
// A sample without the last mark is accepted in the idle state. A sample with
// the last mark starts a run over the n stored samples: the series is first
// centered, then per lag j the products d[t]*d[t-j] are accumulated on the shared
// multiplier, divided on the shared divider and loaded into the output register.
// i_in.ready is low for the whole run. A stalled output holds the next lag in
// the divider until the output register frees. Reset is synchronous, active
// low, and empties the series; the stores need no clearing.
module sample_autocorrelation_core #(
    parameter int MAX_LEN = acf_pkg::MAX_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    acf_in_if.sink      i_in,
    acf_out_if.source   o_res
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int IDX_W  = $clog2(MAX_LEN);
    localparam int SUM_W  = acf_pkg::SAMPLE_W + CNT_W;
    localparam int DEV_W  = SUM_W + 1;
    localparam int PROD_W = 2 * DEV_W;
    localparam int ACC_W  = PROD_W + CNT_W;

    acf_pkg::t_state            r_state, n_state;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    logic [CNT_W-1:0]           r_t, n_t;
    logic [IDX_W-1:0]           r_j, n_j;
    logic                       r_p1, r_p2;
    logic [IDX_W-1:0]           r_a1, r_a2;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc, n_acc;
    logic signed [ACC_W-1:0]    r_den, n_den;
    logic                       r_out_valid, n_out_valid;
    logic [acf_pkg::LAG_W-1:0]  r_out_lag;
    logic signed [acf_pkg::VALUE_W-1:0] r_out_value;
    logic                       r_out_undef;
    logic                       r_out_last;

    logic                       w_in_xfer;
    logic                       w_smp_we;
    logic [acf_pkg::SAMPLE_W-1:0] w_smp_rd;
    logic [DEV_W-1:0]           w_dva_rd, w_dvb_rd;
    logic                       w_dev_we;
    logic [DEV_W-1:0]           w_dev_wd;
    logic [IDX_W-1:0]           w_addr_b;
    logic                       w_issue;
    logic                       w_drained;
    logic signed [DEV_W-1:0]    w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0]   w_prod;
    logic                       w_div_start;
    logic signed [ACC_W-1:0]    w_den;
    logic                       w_load;
    logic                       w_last_lag;
    acf_pkg::t_div_res          w_div;

    // Handshake and store addressing.
    assign i_in.ready = (r_state == acf_pkg::ST_IDLE);
    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_smp_we   = w_in_xfer && (r_cnt < CNT_W'(MAX_LEN));
    assign w_addr_b   = IDX_W'(r_t - CNT_W'(r_j));
    assign w_dev_we   = r_p2 && (r_state == acf_pkg::ST_DEV);
    assign w_dev_wd   = DEV_W'(r_prod - PROD_W'(r_sum));

    // Sample store.
    acf_ram #(.WIDTH(acf_pkg::SAMPLE_W), .DEPTH(MAX_LEN)) u_smp_ram (
        .i_clk   (i_clk),
        .i_we    (w_smp_we),
        .i_waddr (r_cnt[IDX_W-1:0]),
        .i_wdata (i_in.sample),
        .i_raddr (r_t[IDX_W-1:0]),
        .o_rdata (w_smp_rd)
    );

    // Two copies of the centered series so both taps of a lag are read in the same cycle.
    acf_ram #(.WIDTH(DEV_W), .DEPTH(MAX_LEN)) u_dva_ram (
        .i_clk   (i_clk),
        .i_we    (w_dev_we),
        .i_waddr (r_a2),
        .i_wdata (w_dev_wd),
        .i_raddr (r_t[IDX_W-1:0]),
        .o_rdata (w_dva_rd)
    );

    acf_ram #(.WIDTH(DEV_W), .DEPTH(MAX_LEN)) u_dvb_ram (
        .i_clk   (i_clk),
        .i_we    (w_dev_we),
        .i_waddr (r_a2),
        .i_wdata (w_dev_wd),
        .i_raddr (w_addr_b),
        .o_rdata (w_dvb_rd)
    );

    // Shared multiplier: count*sample while centering, d[t]*d[t-j] while correlating.
    always_comb begin
        if (r_state == acf_pkg::ST_DEV) begin
            w_mul_a = DEV_W'($signed({1'b0, r_cnt}));
            w_mul_b = DEV_W'($signed(w_smp_rd));
        end else begin
            w_mul_a = $signed(w_dva_rd);
            w_mul_b = $signed(w_dvb_rd);
        end
        w_prod = w_mul_a * w_mul_b;
    end

    assign w_issue   = ((r_state == acf_pkg::ST_DEV) || (r_state == acf_pkg::ST_MAC))
                       && (r_t < r_cnt);
    assign w_drained = (r_t == r_cnt) && !r_p1 && !r_p2;
    assign w_den     = (r_j == '0) ? r_acc : r_den;
    assign w_last_lag = ((CNT_W'(r_j) + CNT_W'(1)) == r_cnt);

    // Shared divider.
    acf_div #(.ACC_W(ACC_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_acc),
        .i_den   (w_den),
        .o_res   (w_div)
    );

    // Sequencer: next state and control.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        n_t         = r_t;
        n_j         = r_j;
        n_acc       = r_acc;
        n_den       = r_den;
        n_out_valid = r_out_valid && !o_res.ready;
        w_div_start = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            acf_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    if (w_smp_we) begin
                        n_cnt = r_cnt + CNT_W'(1);
                        n_sum = r_sum + SUM_W'(i_in.sample);
                    end
                    if (i_in.last_sample) begin
                        n_state = acf_pkg::ST_DEV;
                        n_t     = '0;
                    end
                end
            end
            acf_pkg::ST_DEV: begin
                if (w_issue) begin
                    n_t = r_t + CNT_W'(1);
                end
                if (w_drained) begin
                    n_state = acf_pkg::ST_MAC;
                    n_j     = '0;
                    n_t     = '0;
                    n_acc   = '0;
                end
            end
            acf_pkg::ST_MAC: begin
                if (w_issue) begin
                    n_t = r_t + CNT_W'(1);
                end
                if (r_p2) begin
                    n_acc = r_acc + ACC_W'(r_prod);
                end
                if (w_drained) begin
                    w_div_start = 1'b1;
                    n_den       = w_den;
                    n_state     = acf_pkg::ST_DIV;
                end
            end
            acf_pkg::ST_DIV: begin
                if (w_div.done) begin
                    n_state = acf_pkg::ST_EMIT;
                end
            end
            acf_pkg::ST_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    if (w_last_lag) begin
                        n_state = acf_pkg::ST_IDLE;
                        n_cnt   = '0;
                        n_sum   = '0;
                    end else begin
                        n_j     = r_j + IDX_W'(1);
                        n_t     = CNT_W'(r_j) + CNT_W'(1);
                        n_acc   = '0;
                        n_state = acf_pkg::ST_MAC;
                    end
                end
            end
            default: begin
                n_state = acf_pkg::ST_IDLE;
            end
        endcase
    end

    // State register and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= acf_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_t         <= '0;
            r_j         <= '0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sum       <= n_sum;
            r_t         <= n_t;
            r_j         <= n_j;
            r_p1        <= w_issue;
            r_p2        <= r_p1;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers: address pipeline, product, accumulator, output.
    always_ff @(posedge i_clk) begin
        r_a1   <= r_t[IDX_W-1:0];
        r_a2   <= r_a1;
        r_prod <= w_prod;
        r_acc  <= n_acc;
        r_den  <= n_den;
        if (w_load) begin
            r_out_lag   <= acf_pkg::LAG_W'(r_j);
            r_out_value <= w_div.value;
            r_out_undef <= w_div.undef;
            r_out_last  <= w_last_lag;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.lag       = r_out_lag;
    assign o_res.acf_value = r_out_value;
    assign o_res.undefined = r_out_undef;
    assign o_res.last_lag  = r_out_last;

    ap_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == acf_pkg::ST_IDLE) |-> (!r_p1 && !r_p2))
        else $error("multiplier pipeline busy while accepting samples");

    ap_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_LEN))
        else $error("sample count beyond store depth");

    ap_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == acf_pkg::ST_DIV))
        else $error("divider result outside the divide step");

    ap_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last_lag) |=> ((r_state == acf_pkg::ST_IDLE) && (r_cnt == '0)
                                    && o_res.valid && o_res.last_lag))
        else $error("run did not close after the last lag");

endmodule

[tb/acf_checker.sv]
// ============================================================================
// acf_checker
// Watches the sample and result channels of the autocorrelation core. It
// predicts the per-lag results of every completed series and compares each
// result transfer, field by field, against the oldest prediction.
// ============================================================================
module acf_checker #(
    parameter int MAX_LEN = acf_pkg::MAX_LEN_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    acf_in_if       in_ch,
    acf_out_if      res_ch,
    output int      o_fail_count,
    output int      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // One predicted result transfer.
    typedef struct packed {
        logic        [acf_pkg::LAG_W-1:0]    lag;
        logic signed [acf_pkg::VALUE_W-1:0]  acf_value;
        logic                                undefined;
        logic                                last_lag;
    } t_acf_result;

    // Shadow copy of the series that the core is collecting.
    logic signed [acf_pkg::SAMPLE_W-1:0] series_mem [MAX_LEN];
    int                                  series_len;
    longint                              series_sum;

    t_acf_result                expected_acf_q [$];
    t_acf_result                want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        series_len   = 0;
        series_sum   = 0;
    end

    // Queue the autocorrelation of every lag of the stored series. Samples
    // are centered as len*x - sum so that every step stays in integers.
    function automatic void predict_acf_run();
        longint                             dev [MAX_LEN];
        longint                             var_sum;
        longint                             cov_sum;
        longint                             mag;
        logic [79:0]                        num_wide;
        logic [79:0]                        quot;
        logic signed [acf_pkg::VALUE_W-1:0] acf_val;
        t_acf_result                        r;
        var_sum = 0;
        for (int t = 0; t < series_len; t++) begin
            dev[t]  = longint'(series_len) * longint'(series_mem[t]) - series_sum;
            var_sum += dev[t] * dev[t];
        end
        for (int j = 0; j < series_len; j++) begin
            cov_sum = 0;
            for (int t = j; t < series_len; t++) begin
                cov_sum += dev[t] * dev[t - j];
            end
            acf_val = '0;
            if (var_sum != 0) begin
                // Divide the magnitude, then restore the sign: truncation toward zero.
                mag      = (cov_sum < 0) ? -cov_sum : cov_sum;
                num_wide = 80'(mag) << acf_pkg::FRAC_W;
                quot     = num_wide / 80'(var_sum);
                acf_val  = quot[acf_pkg::VALUE_W-1:0];
                if (cov_sum < 0) begin
                    acf_val = -acf_val;
                end
            end
            r.lag       = j[acf_pkg::LAG_W-1:0];
            r.acf_value = acf_val;
            r.undefined = (var_sum == 0);
            r.last_lag  = (j == series_len - 1);
            expected_acf_q.push_back(r);
        end
    endfunction

    // Track sample transfers and check result transfers at each edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            series_len = 0;
            series_sum = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                // A full store drops the sample but still honors the last mark.
                if (series_len < MAX_LEN) begin
                    series_mem[series_len] = in_ch.sample;
                    series_len++;
                    series_sum += longint'(in_ch.sample);
                end
                if (in_ch.last_sample) begin
                    predict_acf_run();
                    series_len = 0;
                    series_sum = 0;
                end
            end
            if (res_ch.valid && res_ch.ready) begin
                if (expected_acf_q.size() == 0) begin
                    $error("result for lag %0d arrived with nothing expected", res_ch.lag);
                    o_fail_count++;
                end else begin
                    want = expected_acf_q.pop_front();
                    if (res_ch.lag !== want.lag) begin
                        $error("lag: expected %0d, actual %0d", want.lag, res_ch.lag);
                        o_fail_count++;
                    end
                    if (res_ch.acf_value !== want.acf_value) begin
                        $error("acf_value: expected %0d, actual %0d",
                               want.acf_value, res_ch.acf_value);
                        o_fail_count++;
                    end
                    if (res_ch.undefined !== want.undefined) begin
                        $error("undefined: expected %0b, actual %0b",
                               want.undefined, res_ch.undefined);
                        o_fail_count++;
                    end
                    if (res_ch.last_lag !== want.last_lag) begin
                        $error("last_lag: expected %0b, actual %0b",
                               want.last_lag, res_ch.last_lag);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_acf_q.size();
    end

endmodule

[tb/tb.sv]
// ============================================================================
// tb
// Top of the autocorrelation core testbench. It drives directed and random
// series through the sample channel under several idle and stall patterns,
// holds the result channel off once so that the core backs up, and reports
// the verdict from the checker's failure count.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES    = 3000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 20;

    // Shapes of the random series.
    typedef enum int {
        SER_FULL,
        SER_NARROW,
        SER_CONST,
        SER_EXTREME
    } t_series_kind;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic hold_req = 1'b0;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   quiet_cycles  = 0;
    int   fail_count;
    int   pending;

    acf_in_if  in_ch();
    acf_out_if res_ch();

    sample_autocorrelation_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    acf_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .res_ch       (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result side: random stalls, plus one long hold-off when requested.
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req     <= 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Count cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    // Offer one sample, with a random gap first, and wait for its transfer.
    task automatic send_sample(input logic signed [acf_pkg::SAMPLE_W-1:0] value,
                               input logic is_last);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid       <= 1'b1;
        in_ch.sample      <= value;
        in_ch.last_sample <= is_last;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Stop offering and wait until every predicted result has been checked.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [acf_pkg::SAMPLE_W-1:0] pick_sample(
        input t_series_kind kind, input logic signed [acf_pkg::SAMPLE_W-1:0] level);
        case (kind)
            SER_FULL:    return acf_pkg::SAMPLE_W'($urandom_range(65535));
            SER_NARROW:  return acf_pkg::SAMPLE_W'(int'($urandom_range(8)) - 4);
            SER_CONST:   return level;
            default:     return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    // Send a whole series of the given length; the last sample is marked.
    task automatic send_series(input int len, input t_series_kind kind, inout int count);
        logic signed [acf_pkg::SAMPLE_W-1:0] level;
        level = acf_pkg::SAMPLE_W'($urandom_range(65535));
        for (int i = 0; i < len; i++) begin
            send_sample(pick_sample(kind, level), i == len - 1);
            count++;
        end
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct, input bool_hold,
                                input bit with_overflow);
        int           count;
        int           len;
        int           roll;
        t_series_kind kind;
        count          = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (bool_hold) begin
            hold_req <= 1'b1;
        end
        // A series longer than the store: extra samples are dropped and the
        // last mark lands on a dropped sample.
        if (with_overflow) begin
            send_series(acf_pkg::MAX_LEN_DEF + 2, SER_FULL, count);
        end
        while (count < PHASE_ITEMS) begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
            roll = $urandom_range(99);
            if (roll < 50) begin
                kind = SER_FULL;
            end else if (roll < 70) begin
                kind = SER_NARROW;
            end else if (roll < 85) begin
                kind = SER_CONST;
            end else begin
                kind = SER_EXTREME;
            end
            send_series(len, kind, count);
        end
        drain_results();
    endtask

    initial begin
        in_ch.valid       <= 1'b0;
        in_ch.sample      <= '0;
        in_ch.last_sample <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a lone sample has zero variance.
        send_sample(16'sd1234, 1'b1);
        // A constant series is undefined at every lag.
        send_sample(-16'sd7, 1'b0);
        send_sample(-16'sd7, 1'b0);
        send_sample(-16'sd7, 1'b1);
        // Field extremes and values near zero.
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b1);
        // Two-sample series of opposite extremes.
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
        // Constant at the negative extreme.
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b1);
        // A wide ramp.
        for (int i = 0; i < 8; i++) begin
            send_sample(acf_pkg::SAMPLE_W'(i * 9000 - 32000), i == 7);
        end
        drain_results();

        // Random phases: no idling, sender idle, receiver stalling, both.
        random_phase(0, 0, 1'b0, 1'b1);
        random_phase(87, 0, 1'b0, 1'b0);
        random_phase(0, 87, 1'b0, 1'b0);
        random_phase(14, 14, 1'b1, 1'b0);

        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/acf_pkg.sv
rtl/acf_if.sv
rtl/acf_ram.sv
rtl/acf_div.sv
rtl/sample_autocorrelation_core.sv
tb/acf_checker.sv
tb/tb.sv
